// File: rtl/csar_pkg.sv
package csar_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned QW = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_INT = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  localparam logic signed [QW-1:0] QMax = 32'sh7fffffff;
  localparam logic signed [QW-1:0] QMin = 32'sh80000000;

  // saturate a 64-bit signed value into 32 bits
  function automatic logic signed [QW-1:0] sat64(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > 64'(signed'(QMax))) r = QMax;
    else if (v < 64'(signed'(QMin))) r = QMin;
    else r = v[QW-1:0];
    return r;
  endfunction

  function automatic logic ovf64(input logic signed [63:0] v);
    return (v > 64'(signed'(QMax))) || (v < 64'(signed'(QMin)));
  endfunction

endpackage

// File: rtl/csar_div.sv
// pipelined restoring divider: one quotient bit per stage, signed truncation toward zero
module csar_div import csar_pkg::*; #(
  parameter int unsigned NW  = 49,
  parameter int unsigned DW  = 33,
  parameter int unsigned TW  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] in_num,
  input  logic signed [DW-1:0] in_den,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_vld,
  output logic signed [NW:0]   out_quo,
  output logic [TW-1:0]        out_tag
);

  logic [NW-1:0]   num_r [NW+1];
  logic [DW-1:0]   den_r [NW+1];
  logic [DW:0]     rem_r [NW+1];
  logic [NW-1:0]   quo_r [NW+1];
  logic            neg_r [NW+1];
  logic [TW-1:0]   tag_r [NW+1];
  logic            vld_r [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NW; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= NW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
      den_r[0] <= in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      neg_r[0] <= in_num[NW-1] ^ in_den[DW-1];
      tag_r[0] <= in_tag;
      for (int i = 1; i <= NW; i++) begin
        logic [DW:0] tr;
        logic [DW+1:0] df;
        tr = {rem_r[i-1][DW-1:0], num_r[i-1][NW-i]};
        df = {1'b0, tr} - {2'b0, den_r[i-1]};
        if (!df[DW+1]) begin
          rem_r[i] <= df[DW:0];
          quo_r[i] <= quo_r[i-1] | (NW'(1) << (NW-i));
        end else begin
          rem_r[i] <= tr;
          quo_r[i] <= quo_r[i-1];
        end
        num_r[i] <= num_r[i-1];
        den_r[i] <= den_r[i-1];
        neg_r[i] <= neg_r[i-1];
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign out_tag = tag_r[NW];
  assign out_quo = neg_r[NW] ? -$signed({1'b0, quo_r[NW]}) : $signed({1'b0, quo_r[NW]});

endmodule

// File: rtl/cubic_segment_affine_reparam_top.sv
// pipeline: 50 divider stages (with the default FRAC_BITS) plus 9 arithmetic stages
// throughput: one request per cycle unless stalled; the whole pipeline advances together,
//   so a stalled output holds every stage and one skid-free output register decides
// the divider (one quotient bit per stage) sets the depth
// reset: synchronous active-low rst_n clears all valid bits; data registers keep values
module cubic_segment_affine_reparam_top import csar_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // old_start, old_end, new_start, new_end, coef_0, coef_1, coef_2, coef_3
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_coef_0, new_coef_1, new_coef_2, new_coef_3, status, 6 zero bits
  output logic [135:0] out_tdata
);

  localparam int unsigned NW = 33 + FRAC_BITS;
  localparam int unsigned TW = 6 * QW + 1;
  localparam int unsigned NS = 9;

  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  logic signed [QW-1:0] us_o, ue_o, us_n, ue_n;
  assign us_o = in_tdata[31:0];
  assign ue_o = in_tdata[63:32];
  assign us_n = in_tdata[95:64];
  assign ue_n = in_tdata[127:96];

  logic signed [32:0] num, den;
  assign num = 33'(ue_o) - 33'(us_o);
  assign den = 33'(ue_n) - 33'(us_n);

  logic signed [NW-1:0] num_sh;
  assign num_sh = NW'(num) <<< FRAC_BITS;

  logic [TW-1:0] tag_in, tag_out;
  assign tag_in = {(den == '0), us_n, us_o, in_tdata[255:128]};

  logic div_vld;
  logic signed [NW:0] quo;

  csar_div #(.NW(NW), .DW(33), .TW(TW)) u_div (
    .clk, .rst_n, .en,
    .in_vld (in_tvalid), .in_num(num_sh), .in_den(den), .in_tag(tag_in),
    .out_vld(div_vld), .out_quo(quo), .out_tag(tag_out)
  );

  function automatic logic signed [63:0] fsh(input logic signed [63:0] p);
    return p >>> FRAC_BITS;
  endfunction

  // stage registers
  logic vld_r [NS];
  logic zero_r [NS];
  logic sat_r [NS-1];
  logic signed [QW-1:0] c0_r [NS], c1_r [NS], c2_r [NS], c3_r [NS];
  logic signed [QW-1:0] k0_r [NS], k1_r [NS], uso_r [NS], usn_r [NS];
  logic signed [63:0] pr_r;
  logic signed [QW-1:0] p00_r, p11_r, p01_r, p000_r, p111_r, p001_r, p011_r;
  logic signed [QW-1:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r, m8_r, m9_r;
  logic signed [QW-1:0] m3d_r, m4d_r, m5d_r, r3_r;
  logic signed [35:0] r0_r, r1_r, r2_r;
  logic signed [QW-1:0] o0_r, o1_r, o2_r, o3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= div_vld;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // s0: saturate k1 and unpack the tag
      k1_r[0] <= sat64(64'(quo));
      sat_r[0] <= ovf64(64'(quo));
      {zero_r[0], usn_r[0], uso_r[0], c3_r[0], c2_r[0], c1_r[0], c0_r[0]} <= tag_out;
      for (int i = 1; i < NS; i++) begin
        zero_r[i] <= zero_r[i-1];
        c0_r[i] <= c0_r[i-1]; c1_r[i] <= c1_r[i-1];
        c2_r[i] <= c2_r[i-1]; c3_r[i] <= c3_r[i-1];
        k1_r[i] <= k1_r[i-1];
        uso_r[i] <= uso_r[i-1]; usn_r[i] <= usn_r[i-1];
      end
      for (int i = 3; i < NS; i++) k0_r[i] <= k0_r[i-1];
      // s1: product k1*us_n
      pr_r <= 64'(k1_r[0]) * 64'(usn_r[0]);
      sat_r[1] <= sat_r[0];
      // s2: k0
      k0_r[2] <= sat64(64'(uso_r[1]) - fsh(pr_r));
      sat_r[2] <= sat_r[1] | ovf64(64'(uso_r[1]) - fsh(pr_r));
      // s3: k0*k0, k1*k1, k0*k1
      p00_r <= sat64(fsh(64'(k0_r[2]) * 64'(k0_r[2])));
      p11_r <= sat64(fsh(64'(k1_r[2]) * 64'(k1_r[2])));
      p01_r <= sat64(fsh(64'(k0_r[2]) * 64'(k1_r[2])));
      sat_r[3] <= sat_r[2]
        | ovf64(fsh(64'(k0_r[2]) * 64'(k0_r[2])))
        | ovf64(fsh(64'(k1_r[2]) * 64'(k1_r[2])))
        | ovf64(fsh(64'(k0_r[2]) * 64'(k1_r[2])));
      // s4: cubes and c2 terms
      p000_r <= sat64(fsh(64'(p00_r) * 64'(k0_r[3])));
      p111_r <= sat64(fsh(64'(p11_r) * 64'(k1_r[3])));
      p001_r <= sat64(fsh(64'(p00_r) * 64'(k1_r[3])));
      p011_r <= sat64(fsh(64'(k0_r[3]) * 64'(p11_r)));
      m3_r   <= sat64(fsh(64'(c2_r[3]) * 64'(p00_r)));
      m4_r   <= sat64(fsh(64'(c2_r[3]) * 64'(p01_r)));
      m5_r   <= sat64(fsh(64'(c2_r[3]) * 64'(p11_r)));
      sat_r[4] <= sat_r[3]
        | ovf64(fsh(64'(p00_r) * 64'(k0_r[3])))
        | ovf64(fsh(64'(p11_r) * 64'(k1_r[3])))
        | ovf64(fsh(64'(p00_r) * 64'(k1_r[3])))
        | ovf64(fsh(64'(k0_r[3]) * 64'(p11_r)))
        | ovf64(fsh(64'(c2_r[3]) * 64'(p00_r)))
        | ovf64(fsh(64'(c2_r[3]) * 64'(p01_r)))
        | ovf64(fsh(64'(c2_r[3]) * 64'(p11_r)));
      // s5: c3 terms, c1 terms, c2 terms held one stage
      m1_r <= sat64(fsh(64'(c1_r[4]) * 64'(k0_r[4])));
      m2_r <= sat64(fsh(64'(c1_r[4]) * 64'(k1_r[4])));
      m6_r <= sat64(fsh(64'(c3_r[4]) * 64'(p000_r)));
      m7_r <= sat64(fsh(64'(c3_r[4]) * 64'(p001_r)));
      m8_r <= sat64(fsh(64'(c3_r[4]) * 64'(p011_r)));
      m9_r <= sat64(fsh(64'(c3_r[4]) * 64'(p111_r)));
      m3d_r <= m3_r;
      m4d_r <= m4_r;
      m5d_r <= m5_r;
      sat_r[5] <= sat_r[4]
        | ovf64(fsh(64'(c1_r[4]) * 64'(k0_r[4])))
        | ovf64(fsh(64'(c1_r[4]) * 64'(k1_r[4])))
        | ovf64(fsh(64'(c3_r[4]) * 64'(p000_r)))
        | ovf64(fsh(64'(c3_r[4]) * 64'(p001_r)))
        | ovf64(fsh(64'(c3_r[4]) * 64'(p011_r)))
        | ovf64(fsh(64'(c3_r[4]) * 64'(p111_r)));
      // s6: exact sums
      r0_r <= 36'(c0_r[5]) + 36'(m1_r) + 36'(m3d_r) + 36'(m6_r);
      r1_r <= 36'(m2_r) + 36'(m4d_r) * 36'sd2 + 36'(m7_r) * 36'sd3;
      r2_r <= 36'(m5d_r) + 36'(m8_r) * 36'sd3;
      r3_r <= m9_r;
      sat_r[6] <= sat_r[5];
      // s7: final saturation
      o0_r <= sat64(64'(r0_r));
      o1_r <= sat64(64'(r1_r));
      o2_r <= sat64(64'(r2_r));
      o3_r <= r3_r;
      sat_r[7] <= sat_r[6] | ovf64(64'(r0_r)) | ovf64(64'(r1_r)) | ovf64(64'(r2_r));
      // s8: zero-interval override
      if (zero_r[7]) begin
        out_tdata <= {6'b0, 2'(ST_ZERO_INT), 128'b0};
      end else begin
        out_tdata <= {6'b0, sat_r[7] ? 2'(ST_SAT) : 2'(ST_OK), o3_r, o2_r, o1_r, o0_r};
      end
    end
  end

  assign out_tvalid = vld_r[NS-1];

endmodule
